[sv/suvip_pkg.sv]
package suvip_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int IDX_W     = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int VAL_W     = 32;

	typedef enum logic [12:0] {
		ST_LOAD   = 13'b0000000000001,
		ST_MRD    = 13'b0000000000010,
		ST_MVI    = 13'b0000000000100,
		ST_MSCAN  = 13'b0000000001000,
		ST_MEND   = 13'b0000000010000,
		ST_PSTART = 13'b0000000100000,
		ST_P0     = 13'b0000001000000,
		ST_P1     = 13'b0000010000000,
		ST_STEPA  = 13'b0000100000000,
		ST_STEPB  = 13'b0001000000000,
		ST_STEPC  = 13'b0010000000000,
		ST_PEND   = 13'b0100000000000,
		ST_EMIT   = 13'b1000000000000
	} state_t;

endpackage

[sv/sort_unique_values_in_place.sv]
// Collects an array of signed 32-bit words on the s_ stream; the word with
// s_tlast high closes the array. Words beyond MAX_ITEMS are dropped, but a
// dropped word with s_tlast still closes the array. Every value that occurs
// exactly once is then sorted ascending across the positions such values
// already hold; repeated values keep their places. The whole array leaves on
// the m_ stream in position order, with m_tlast on its final word.
// Loading accepts a word whenever s_tvalid is high. The uniqueness check
// scans the whole array through the one store port for each element. The
// bubble sort over k unique values runs each compare as a position read,
// an element read, and a compare with write back, and ends early after a
// pass without a swap. Emission issues one element store read per word and
// issues no further read until that one has returned. s_tready is high only
// while loading. A stall on m_tready holds the current output word and
// pauses emission; no word is lost. Reset returns the block to loading with
// an empty array and no output word pending.
module sort_unique_values_in_place
	import suvip_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [VAL_W-1:0] s_tdata,  // [31:0] value
	input  logic             s_tlast,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [VAL_W-1:0] m_tdata,  // [31:0] value_res
	output logic             m_tlast
);

	logic [VAL_W-1:0] store_mem [MAX_ITEMS];
	logic [IDX_W-1:0] pos_mem [MAX_ITEMS];

	state_t state_q;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] j_q;
	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] limit_q;
	logic [CNT_W-1:0] si_q;
	logic [CNT_W-1:0] e_q;
	logic [VAL_W-1:0] vi_q;
	logic             dup_q;
	logic             swapped_q;
	logic [IDX_W-1:0] lo_q;
	logic [IDX_W-1:0] hi_q;
	logic signed [VAL_W-1:0] cv_q;

	logic             cmp_s1;
	logic [IDX_W-1:0] jt_s1;
	logic             pend_s1;
	logic             elast_s1;

	logic             out_valid_q;
	logic [VAL_W-1:0] out_data_q;
	logic             out_last_q;

	logic signed [VAL_W-1:0] rdata_q;
	logic [IDX_W-1:0]        pdata_q;

	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] prd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [VAL_W-1:0] wr_data;
	logic             pwr_en;

	logic             s_acc;
	logic             hit;
	logic             dup_all;
	logic [CNT_W-1:0] k_next;
	logic             issue;

	assign s_tready = (state_q == ST_LOAD);
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// Compare stage of the uniqueness scan: the element read last cycle against vi.
	assign hit     = cmp_s1 && (jt_s1 != i_q[IDX_W-1:0]) && (rdata_q == vi_q);
	assign dup_all = dup_q || hit;
	assign k_next  = dup_all ? k_q : k_q + CNT_W'(1);

	assign issue = (state_q == ST_EMIT) && !pend_s1 && (e_q != n_q)
		&& (!out_valid_q || m_tready);

	always_comb begin
		rd_addr = i_q[IDX_W-1:0];
		prd_addr = '0;
		wr_en = 1'b0;
		wr_addr = cnt_q[IDX_W-1:0];
		wr_data = s_tdata;
		pwr_en = 1'b0;
		case (state_q)
			ST_LOAD: begin
				wr_en = s_acc && (cnt_q != CNT_W'(MAX_ITEMS));
			end
			ST_MSCAN: begin
				rd_addr = j_q[IDX_W-1:0];
			end
			ST_MEND: begin
				pwr_en = !dup_all;
			end
			ST_PSTART: begin
				prd_addr = '0;
			end
			ST_P0: begin
				rd_addr = pdata_q;
			end
			ST_STEPA: begin
				prd_addr = si_q[IDX_W-1:0];
			end
			ST_STEPB: begin
				rd_addr = pdata_q;
			end
			ST_STEPC: begin
				wr_en = 1'b1;
				wr_addr = lo_q;
				wr_data = ($signed(rdata_q) < cv_q) ? rdata_q : cv_q;
			end
			ST_PEND: begin
				wr_en = 1'b1;
				wr_addr = lo_q;
				wr_data = cv_q;
			end
			ST_EMIT: begin
				rd_addr = e_q[IDX_W-1:0];
			end
			default: begin
				rd_addr = i_q[IDX_W-1:0];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[wr_addr] <= wr_data;
		end
		rdata_q <= store_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (pwr_en) begin
			pos_mem[k_q[IDX_W-1:0]] <= i_q[IDX_W-1:0];
		end
		pdata_q <= pos_mem[prd_addr];
	end

	always_ff @(posedge clk) begin
		jt_s1 <= j_q[IDX_W-1:0];
		elast_s1 <= (e_q == n_q - CNT_W'(1));
		case (state_q)
			ST_MVI: begin
				vi_q <= rdata_q;
			end
			ST_P0: begin
				lo_q <= pdata_q;
			end
			ST_P1: begin
				cv_q <= rdata_q;
			end
			ST_STEPB: begin
				hi_q <= pdata_q;
			end
			ST_STEPC: begin
				lo_q <= hi_q;
				if (!($signed(rdata_q) < cv_q)) begin
					cv_q <= rdata_q;
				end
			end
			default: begin
				vi_q <= vi_q;
			end
		endcase
		if (pend_s1) begin
			out_data_q <= rdata_q;
			out_last_q <= elast_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q <= '0;
			n_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			limit_q <= '0;
			si_q <= '0;
			e_q <= '0;
			dup_q <= 1'b0;
			swapped_q <= 1'b0;
			cmp_s1 <= 1'b0;
			pend_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cmp_s1 <= (state_q == ST_MSCAN);
			pend_s1 <= issue;
			if (pend_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (hit) begin
				dup_q <= 1'b1;
			end
			case (state_q)
				ST_LOAD: begin
					i_q <= '0;
					k_q <= '0;
					e_q <= '0;
					if (s_acc) begin
						if (cnt_q != CNT_W'(MAX_ITEMS)) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						if (s_tlast) begin
							n_q <= (cnt_q != CNT_W'(MAX_ITEMS)) ? cnt_q + CNT_W'(1) : cnt_q;
							state_q <= ST_MRD;
						end
					end
				end
				ST_MRD: begin
					state_q <= ST_MVI;
				end
				ST_MVI: begin
					j_q <= '0;
					dup_q <= 1'b0;
					state_q <= ST_MSCAN;
				end
				ST_MSCAN: begin
					j_q <= j_q + CNT_W'(1);
					if (j_q == n_q - CNT_W'(1)) begin
						state_q <= ST_MEND;
					end
				end
				ST_MEND: begin
					k_q <= k_next;
					i_q <= i_q + CNT_W'(1);
					if (i_q + CNT_W'(1) == n_q) begin
						limit_q <= k_next;
						state_q <= ST_PSTART;
					end else begin
						state_q <= ST_MRD;
					end
				end
				ST_PSTART: begin
					if (limit_q < CNT_W'(2)) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_P0;
					end
				end
				ST_P0: begin
					state_q <= ST_P1;
				end
				ST_P1: begin
					si_q <= CNT_W'(1);
					swapped_q <= 1'b0;
					state_q <= ST_STEPA;
				end
				ST_STEPA: begin
					state_q <= ST_STEPB;
				end
				ST_STEPB: begin
					state_q <= ST_STEPC;
				end
				ST_STEPC: begin
					if ($signed(rdata_q) < cv_q) begin
						swapped_q <= 1'b1;
					end
					si_q <= si_q + CNT_W'(1);
					if (si_q + CNT_W'(1) == limit_q) begin
						state_q <= ST_PEND;
					end else begin
						state_q <= ST_STEPA;
					end
				end
				ST_PEND: begin
					if (swapped_q) begin
						limit_q <= limit_q - CNT_W'(1);
						state_q <= ST_PSTART;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (issue) begin
						e_q <= e_q + CNT_W'(1);
					end
					if ((e_q == n_q) && !pend_s1) begin
						cnt_q <= '0;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule
